// File: rtl/pngunf_pkg.sv
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types, sizes and the paeth predictor for the png scanline unfilter.
// ----------------------------------------------------------------------------
package pngunf_pkg;

  localparam int MAX_ROW_BYTES   = 4096;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int BPP_W   = 4;                          // pixel size register
  localparam int ROW_W   = 13;                         // row_bytes register
  localparam int COL_W   = $clog2(MAX_ROW_BYTES);      // column / store address
  localparam int RING_N  = 8;                          // recent byte rings
  localparam int RING_W  = $clog2(RING_N);
  localparam int CFG_W   = ROW_W;                      // widest register

  // register indexes on the config port
  localparam logic CFG_BPP = 1'b0;
  localparam logic CFG_ROW = 1'b1;

  // filter kinds, unknown types fold into FILT_BAD
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  // one data item on its way from the address stage to the compute stage
  typedef struct packed {
    logic [7:0]       x;
    logic [COL_W-1:0] col;
    logic             has_left;
    logic [RING_W-1:0] ridx;
    logic             last;
    logic             first;
    filt_t            filt;
  } s1_item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    // p = a + b - c, so p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// File: rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Undoes the png per-row filters on a decompressed byte stream.
// ----------------------------------------------------------------------------
//
//  channel  dir  ports                         payload
//  in       in   in_tvalid/in_tready/in_tdata  tdata: data_byte, tuser: start_of_image
//  out      out  out_tvalid/out_tready/...     tdata: pixel_byte, tlast: end_of_row,
//                                              tuser: bad_filter
//  cfg      in   cfg_we/cfg_addr/cfg_wdata     0: pixel size, 1: row_bytes
//
//  one item per cycle sustained while out_tready stays high; a data byte is
//  registered in stage 1 with its store read, then computed into the output register
//  the filter byte of each row is taken and gives no output
//  reset clears control and config; the prior row store holds no reset state
//  out_tready low holds the output register; the compute stage and the
//  input keep moving while the output register or the compute stage is free
// ----------------------------------------------------------------------------
module png_scanline_unfilter (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tuser,   // [0] start_of_image
  // result item channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] pixel_byte
  output logic                        out_tlast,  // end_of_row
  output logic                        out_tuser,  // [0] bad_filter
  // configuration writes
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [pngunf_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int COL_W  = pngunf_pkg::COL_W;
  localparam int ROW_W  = pngunf_pkg::ROW_W;
  localparam int BPP_W  = pngunf_pkg::BPP_W;
  localparam int RING_W = pngunf_pkg::RING_W;

  // ---------------------------------------------------------------- config
  logic [BPP_W-1:0] bpp_r;
  logic [ROW_W-1:0] row_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= BPP_W'(1);
      row_len_r <= ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        pngunf_pkg::CFG_BPP: bpp_r     <= cfg_wdata[BPP_W-1:0];
        pngunf_pkg::CFG_ROW: row_len_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range register values clamp to the legal range
  logic [BPP_W-1:0] bpp_eff;
  logic [ROW_W-1:0] row_eff;

  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_r > BPP_W'(pngunf_pkg::MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(pngunf_pkg::MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_r;
    end
    if (row_len_r == '0) begin
      row_eff = ROW_W'(1);
    end else if (row_len_r > ROW_W'(pngunf_pkg::MAX_ROW_BYTES)) begin
      row_eff = ROW_W'(pngunf_pkg::MAX_ROW_BYTES);
    end else begin
      row_eff = row_len_r;
    end
  end

  // ---------------------------------------------------------------- stage 0
  // row tracking and the prior row store read address
  logic [COL_W-1:0]  col_r, col_nxt;
  pngunf_pkg::filt_t filt_r, filt_nxt;
  logic              expect_r, expect_nxt;   // next byte is a filter byte
  logic              first_r, first_nxt;     // current row is the image's first

  logic              s1_v_r, s1_v_nxt;
  pngunf_pkg::s1_item_t s1_r;
  pngunf_pkg::s1_item_t s1_in;

  logic              out_v_r, out_v_nxt;
  logic              s1_adv;
  logic              in_acc;
  logic              is_filt;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_m1;
  logic              last0;
  logic              rd_en;

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign is_filt   = in_tuser || expect_r;
  assign rd_en     = in_acc && !is_filt;

  always_comb begin
    row_m1  = row_eff - ROW_W'(1);
    // a column left beyond a shortened row ends that row on this byte
    col_eff = ({1'b0, col_r} >= row_eff) ? row_m1[COL_W-1:0] : col_r;
    last0   = ({1'b0, col_eff} + ROW_W'(1)) >= row_eff;

    s1_in.x        = in_tdata;
    s1_in.col      = col_eff;
    s1_in.has_left = col_eff >= COL_W'(bpp_eff);
    s1_in.ridx     = col_eff[RING_W-1:0] - bpp_eff[RING_W-1:0];
    s1_in.last     = last0;
    s1_in.first    = first_r;
    s1_in.filt     = filt_r;
  end

  always_comb begin
    col_nxt    = col_r;
    filt_nxt   = filt_r;
    expect_nxt = expect_r;
    first_nxt  = first_r;
    if (in_acc) begin
      if (is_filt) begin
        // filter byte opens a row; a start mark also restarts the image
        if (in_tuser) begin
          first_nxt = 1'b1;
        end
        filt_nxt   = (in_tdata > 8'(pngunf_pkg::FILT_PAETH))
                     ? pngunf_pkg::FILT_BAD
                     : pngunf_pkg::filt_t'(in_tdata[2:0]);
        col_nxt    = '0;
        expect_nxt = 1'b0;
      end else if (last0) begin
        expect_nxt = 1'b1;
        first_nxt  = 1'b0;
        col_nxt    = '0;
      end else begin
        col_nxt = col_eff + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      filt_r   <= pngunf_pkg::FILT_NONE;
      expect_r <= 1'b1;
      first_r  <= 1'b1;
    end else begin
      col_r    <= col_nxt;
      filt_r   <= filt_nxt;
      expect_r <= expect_nxt;
      first_r  <= first_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    if (rd_en) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r <= s1_in;
    end
  end

  // prior row store, one write and one read port, registered read data
  logic [7:0] prior_mem [pngunf_pkg::MAX_ROW_BYTES];
  logic [7:0] rdata_r;
  logic [7:0] res;
  logic       fwd;

  // same column written and read in one cycle: hand over the new byte
  assign fwd = s1_adv && (s1_r.col == col_eff);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prior_mem[s1_r.col] <= res;
    end
    if (rd_en) begin
      rdata_r <= fwd ? res : prior_mem[col_eff];
    end
  end

  // rings of the last eight current-row and above-row bytes, by column mod 8
  logic [7:0] ring_cur_r [pngunf_pkg::RING_N];
  logic [7:0] ring_abv_r [pngunf_pkg::RING_N];

  logic [7:0] a_val;
  logic [7:0] b_val;
  logic [7:0] c_val;
  logic [8:0] ab_sum;
  logic [7:0] add_val;

  always_comb begin
    b_val  = s1_r.first ? 8'd0 : rdata_r;
    a_val  = s1_r.has_left ? ring_cur_r[s1_r.ridx] : 8'd0;
    c_val  = s1_r.has_left ? ring_abv_r[s1_r.ridx] : 8'd0;
    ab_sum = {1'b0, a_val} + {1'b0, b_val};
    case (s1_r.filt)
      pngunf_pkg::FILT_NONE:  add_val = 8'd0;
      pngunf_pkg::FILT_SUB:   add_val = a_val;
      pngunf_pkg::FILT_UP:    add_val = b_val;
      pngunf_pkg::FILT_AVG:   add_val = ab_sum[8:1];
      pngunf_pkg::FILT_PAETH: add_val = pngunf_pkg::paeth(a_val, b_val, c_val);
      default:                add_val = 8'd0;   // unknown type passes through
    endcase
    res = s1_r.x + add_val;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ring_cur_r[s1_r.col[RING_W-1:0]] <= res;
      ring_abv_r[s1_r.col[RING_W-1:0]] <= b_val;
    end
  end

  // ---------------------------------------------------------------- output
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_bad_r;

  always_comb begin
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
      out_last_r <= s1_r.last;
      out_bad_r  <= (s1_r.filt == pngunf_pkg::FILT_BAD);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  // a filter byte opens the row and puts nothing into the compute stage
  a_filt_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_filt) |=> (!expect_r && !s1_v_r))
    else $error("filter byte left an item or kept waiting for a filter byte");

  // every data byte reaches the compute stage
  a_data_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_filt) |=> s1_v_r)
    else $error("data byte lost before the compute stage");

  // the last byte of a row makes the next byte a filter byte of a later row
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_filt && last0) |=> (expect_r && !first_r))
    else $error("row end not followed by a filter byte");

  // read data must hold while the compute stage is stalled
  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> $stable(rdata_r))
    else $error("store read data changed under a stalled item");
`endif

endmodule
